[hdl/aloha_stop_and_wait_arq_core_defines.svh]
// Assertion macros for the stop-and-wait ARQ core.
// Each macro checks a property on clk, disabled while rst_n is low.
`ifndef ALOHA_STOP_AND_WAIT_ARQ_CORE_DEFINES_SVH
`define ALOHA_STOP_AND_WAIT_ARQ_CORE_DEFINES_SVH

// Check that cons holds in the cycle in which ante holds
`define ASWARQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds
`define ASWARQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/aswarq_pkg.sv]
// Shared types and codes for the stop-and-wait ARQ core.
// No dependencies; every module in the project imports this package.
package aswarq_pkg;

  // Input commands
  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_FRAME   = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // Received frame kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;

  // Result actions
  localparam logic [2:0] ACT_SEND_DATA = 3'd0;
  localparam logic [2:0] ACT_SEND_ACK  = 3'd1;
  localparam logic [2:0] ACT_DELIVER   = 3'd2;
  localparam logic [2:0] ACT_ACKED     = 3'd3;
  localparam logic [2:0] ACT_GAVE_UP   = 3'd4;
  localparam logic [2:0] ACT_ERROR     = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_FUTURE_ACK = 2'd1;
  localparam logic [1:0] ERR_OLD_ACK    = 2'd2;
  localparam logic [1:0] ERR_UNDEFINED  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOCAL_ADDR  = 2'd0;
  localparam logic [1:0] CFG_PEER_ADDR   = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd3;

  // Configuration reset values
  localparam logic [47:0] RST_LOCAL_ADDR  = 48'hF009_E090_E90E;
  localparam logic [47:0] RST_PEER_ADDR   = 48'h00F0_F0F0_F0F0;
  localparam logic [15:0] RST_ACK_TIMEOUT = 16'd100;
  localparam logic [7:0]  RST_MAX_RETRIES = 8'd100;

  // Sequence and backoff constants
  localparam logic [31:0] SEQ_FIRST    = 32'd1;
  localparam logic [31:0] SEQ_LAST     = 32'hFFFF_FFFE;
  localparam logic [15:0] LFSR_SEED    = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_BACKOFF
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_EMIT0,
    ST_EMIT1
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] frame_dst;
    logic [47:0] frame_src;
    logic [1:0]  frame_kind;
    logic [31:0] frame_seqno;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] out_src;
    logic [47:0] out_dst;
    logic [31:0] out_seqno;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic commit;
    logic div_start;
    logic div_commit;
    logic emit;
    logic emit_sel;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       need_div;
    logic [1:0] res_count;
    logic       pend_two;
    logic       div_busy;
    logic       div_done;
    logic       out_free;
  } ctrl_sts_t;

endpackage

[hdl/aswarq_divider.sv]
// Iterative 16-bit remainder unit, one quotient bit per cycle.
// Uses aswarq_pkg only for the common import style.
module aswarq_divider
  import aswarq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] remainder
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] rem_sh;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, dvd_r[15]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      rem_nxt  = 16'd0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[14:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(rem_sh - {1'b0, dvs_r});
      end else begin
        rem_nxt = rem_sh[15:0];
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[hdl/aswarq_datapath.sv]
// Datapath: configuration, protocol state, result staging and output register.
// Uses aswarq_pkg and instantiates aswarq_divider for the backoff remainder.
module aswarq_datapath
  import aswarq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  in_item_t    in_data,
  output out_item_t   out_data,
  output logic        out_valid,
  input  logic        out_ready,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts
);

  localparam int QW = $clog2(QUEUE_DEPTH + 1);

  logic [47:0] local_addr_r;
  logic [47:0] peer_addr_r;
  logic [15:0] ack_timeout_r;
  logic [7:0]  max_retries_r;

  in_item_t    item_r;
  logic [31:0] tx_seq_r, tx_seq_nxt;
  logic [31:0] rx_last_r, rx_last_nxt;
  phase_t      phase_r, phase_nxt;
  logic [16:0] wait_r, wait_nxt;
  logic [8:0]  send_cnt_r, send_cnt_nxt;
  logic [QW-1:0] queued_r, queued_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;

  out_item_t   pend0_r, pend1_r;
  logic        pend_two_r;
  out_item_t   out_r;
  logic        out_valid_r;

  out_item_t   res [2];
  out_item_t   res0_fin, res1_fin;
  logic [1:0]  res_cnt;
  logic        need_div;
  logic [15:0] teff;
  logic [31:0] seq_inc;
  logic [16:0] tick_wait;
  logic        div_busy, div_done;
  logic [15:0] div_rem;

  function automatic out_item_t mk_res(input logic [2:0] act, input logic [47:0] src,
                                       input logic [47:0] dst, input logic [31:0] seq,
                                       input logic [1:0] err);
    out_item_t r;
    r.action     = act;
    r.out_src    = src;
    r.out_dst    = dst;
    r.out_seqno  = seq;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  // Effective timeout and next sequence number
  assign teff    = (ack_timeout_r == 16'd0) ? 16'd1 : ack_timeout_r;
  assign seq_inc = (tx_seq_r == SEQ_LAST) ? SEQ_FIRST : tx_seq_r + 32'd1;
  assign tick_wait = (wait_r != 17'd0) ? wait_r - 17'd1 : 17'd0;

  // Work out the results and state update of the held transaction
  always_comb begin
    logic try_start;
    tx_seq_nxt   = tx_seq_r;
    rx_last_nxt  = rx_last_r;
    phase_nxt    = phase_r;
    wait_nxt     = wait_r;
    send_cnt_nxt = send_cnt_r;
    queued_nxt   = queued_r;
    lfsr_nxt     = lfsr_r;
    res[0]       = mk_res(ACT_ERROR, 48'd0, 48'd0, 32'd0, ERR_NONE);
    res[1]       = res[0];
    res_cnt      = 2'd0;
    need_div     = 1'b0;
    try_start    = 1'b0;
    case (item_r.command)
      CMD_REQUEST: begin
        if (queued_r >= QW'(QUEUE_DEPTH)) begin
          res[res_cnt[0]] = mk_res(ACT_ERROR, 48'd0, 48'd0, 32'd0, ERR_UNDEFINED);
          res_cnt = res_cnt + 2'd1;
        end else begin
          queued_nxt = queued_r + QW'(1);
        end
        try_start = 1'b1;
      end
      CMD_FRAME: begin
        if (item_r.frame_dst == local_addr_r) begin
          if (item_r.frame_kind == KIND_DATA) begin
            res[res_cnt[0]] = mk_res(ACT_SEND_ACK, local_addr_r, item_r.frame_src,
                                     item_r.frame_seqno, ERR_NONE);
            res_cnt = res_cnt + 2'd1;
            if (item_r.frame_seqno > rx_last_r || item_r.frame_seqno == SEQ_FIRST) begin
              res[res_cnt[0]] = mk_res(ACT_DELIVER, item_r.frame_src, item_r.frame_dst,
                                       item_r.frame_seqno, ERR_NONE);
              res_cnt = res_cnt + 2'd1;
              rx_last_nxt = item_r.frame_seqno;
            end
          end else if (item_r.frame_kind == KIND_ACK) begin
            if (item_r.frame_seqno == tx_seq_r) begin
              // Matching ACK completes the frame unless nothing is in flight
              if (phase_r != PH_IDLE) begin
                res[res_cnt[0]] = mk_res(ACT_ACKED, 48'd0, 48'd0, tx_seq_r, ERR_NONE);
                res_cnt = res_cnt + 2'd1;
                tx_seq_nxt   = seq_inc;
                phase_nxt    = PH_IDLE;
                wait_nxt     = 17'd0;
                send_cnt_nxt = 9'd0;
                try_start    = 1'b1;
              end
            end else if (item_r.frame_seqno > tx_seq_r) begin
              res[res_cnt[0]] = mk_res(ACT_ERROR, 48'd0, 48'd0, item_r.frame_seqno,
                                       ERR_FUTURE_ACK);
              res_cnt = res_cnt + 2'd1;
            end else begin
              res[res_cnt[0]] = mk_res(ACT_ERROR, 48'd0, 48'd0, item_r.frame_seqno,
                                       ERR_OLD_ACK);
              res_cnt = res_cnt + 2'd1;
            end
          end else begin
            res[res_cnt[0]] = mk_res(ACT_ERROR, 48'd0, 48'd0, item_r.frame_seqno,
                                     ERR_UNDEFINED);
            res_cnt = res_cnt + 2'd1;
          end
        end
      end
      CMD_TICK: begin
        if (phase_r != PH_IDLE) begin
          wait_nxt = tick_wait;
          if (tick_wait == 17'd0) begin
            if (phase_r == PH_WAIT) begin
              // Step the LFSR and hand its new value to the divider
              lfsr_nxt  = lfsr_r[0] ? ({1'b0, lfsr_r[15:1]} ^ LFSR_TAPS)
                                    : {1'b0, lfsr_r[15:1]};
              phase_nxt = PH_BACKOFF;
              need_div  = 1'b1;
            end else if (send_cnt_r >= {1'b0, max_retries_r} + 9'd1) begin
              res[res_cnt[0]] = mk_res(ACT_GAVE_UP, 48'd0, 48'd0, tx_seq_r, ERR_NONE);
              res_cnt = res_cnt + 2'd1;
              tx_seq_nxt   = seq_inc;
              phase_nxt    = PH_IDLE;
              wait_nxt     = 17'd0;
              send_cnt_nxt = 9'd0;
              try_start    = 1'b1;
            end else begin
              res[res_cnt[0]] = mk_res(ACT_SEND_DATA, local_addr_r, peer_addr_r,
                                       tx_seq_r, ERR_NONE);
              res_cnt = res_cnt + 2'd1;
              send_cnt_nxt = send_cnt_r + 9'd1;
              phase_nxt    = PH_WAIT;
              wait_nxt     = {1'b0, teff};
            end
          end
        end
      end
      default: begin
      end
    endcase
    // Start the next queued request once the engine is free
    if (try_start && phase_nxt == PH_IDLE && queued_nxt != '0) begin
      queued_nxt   = queued_nxt - QW'(1);
      send_cnt_nxt = 9'd1;
      phase_nxt    = PH_WAIT;
      wait_nxt     = {1'b0, teff};
      res[res_cnt[0]] = mk_res(ACT_SEND_DATA, local_addr_r, peer_addr_r, tx_seq_nxt,
                               ERR_NONE);
      res_cnt = res_cnt + 2'd1;
    end
  end

  // Mark the final result of the transaction
  always_comb begin
    res0_fin      = res[0];
    res0_fin.last = (res_cnt == 2'd1);
    res1_fin      = res[1];
    res1_fin.last = 1'b1;
  end

  aswarq_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (lfsr_nxt),
    .divisor   (teff),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r  <= RST_LOCAL_ADDR;
      peer_addr_r   <= RST_PEER_ADDR;
      ack_timeout_r <= RST_ACK_TIMEOUT;
      max_retries_r <= RST_MAX_RETRIES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_ADDR:  local_addr_r  <= cfg_wdata;
        CFG_PEER_ADDR:   peer_addr_r   <= cfg_wdata;
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[15:0];
        CFG_MAX_RETRIES: max_retries_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Protocol state: commit decode results, then the backoff length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_seq_r   <= SEQ_FIRST;
      rx_last_r  <= 32'd0;
      phase_r    <= PH_IDLE;
      wait_r     <= 17'd0;
      send_cnt_r <= 9'd0;
      queued_r   <= '0;
      lfsr_r     <= LFSR_SEED;
    end else if (cmd.commit) begin
      tx_seq_r   <= tx_seq_nxt;
      rx_last_r  <= rx_last_nxt;
      phase_r    <= phase_nxt;
      wait_r     <= wait_nxt;
      send_cnt_r <= send_cnt_nxt;
      queued_r   <= queued_nxt;
      lfsr_r     <= lfsr_nxt;
    end else if (cmd.div_commit) begin
      wait_r <= {1'b0, teff} + {1'b0, div_rem};
    end
  end

  // Hold the accepted transaction and the staged results
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      pend0_r <= res0_fin;
      pend1_r <= res1_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_two_r <= 1'b0;
    end else if (cmd.commit) begin
      pend_two_r <= (res_cnt == 2'd2);
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= cmd.emit_sel ? pend1_r : pend0_r;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  always_comb begin
    sts.need_div  = need_div;
    sts.res_count = res_cnt;
    sts.pend_two  = pend_two_r;
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

[hdl/aswarq_ctrl.sv]
// Controller: sequences accept, decode, backoff division and result emission.
// Uses aswarq_pkg and the assertion macros header.
`include "aloha_stop_and_wait_arq_core_defines.svh"

module aswarq_ctrl
  import aswarq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.need_div) begin
          state_nxt = ST_DIV;
        end else if (sts.res_count == 2'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT0;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT0: begin
        if (sts.out_free) begin
          state_nxt = sts.pend_two ? ST_EMIT1 : ST_IDLE;
        end
      end
      ST_EMIT1: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.load_item  = 1'b0;
    cmd.commit     = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.div_commit = 1'b0;
    cmd.emit       = 1'b0;
    cmd.emit_sel   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECODE: begin
        cmd.commit    = 1'b1;
        cmd.div_start = sts.need_div;
      end
      ST_DIV: begin
        cmd.div_commit = sts.div_done;
      end
      ST_EMIT0: begin
        cmd.emit = sts.out_free;
      end
      ST_EMIT1: begin
        cmd.emit     = sts.out_free;
        cmd.emit_sel = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASWARQ_ASSERT_SAME(a_emit_slot_free, cmd.emit, sts.out_free, "result overwrote output")
  `ASWARQ_ASSERT_SAME(a_second_staged, state_r == ST_EMIT1, sts.pend_two, "no second result")
  `ASWARQ_ASSERT_SAME(a_div_running, state_r == ST_DIV, sts.div_busy || sts.div_done, "divider idle")
  `ASWARQ_ASSERT_NEXT(a_div_started, cmd.div_start, sts.div_busy, "divider did not start")

endmodule

[hdl/aloha_stop_and_wait_arq_core.sv]
// Stop-and-wait ALOHA ARQ engine: one transaction in flight at a time. A transmit
// request or frame header is accepted and decoded, then each result it causes (at
// most two) is emitted once the output register is free. A tick that ends the ACK
// wait is decoded and then waits on the sixteen-step remainder unit that sizes the
// backoff. Config writes go straight to the registers through cfg_we.
module aloha_stop_and_wait_arq_core
  import aswarq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  aswarq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aswarq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for the stop-and-wait ARQ core: random stimulus on
// valid/ready channels, checked against an in-bench model of the MAC engine.
// Depends on aswarq_pkg and aloha_stop_and_wait_arq_core.
`timescale 1ns / 100ps

module tb;
  import aswarq_pkg::*;

  localparam int QUEUE_DEPTH = 128;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 3000;
  localparam int REPORT_MAX = 10;

  // Command and frame kinds with no name in the package
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] KIND_UNDEF_LO = 2'd2;
  localparam logic [1:0] KIND_UNDEF_HI = 2'd3;

  // How the driver fills in frame_seqno when it presents an item
  typedef enum logic [2:0] {
    SEQ_AS_GIVEN,
    SEQ_OWN_CUR,
    SEQ_OWN_AHEAD,
    SEQ_OWN_BEHIND,
    SEQ_PEER_NEXT
  } seq_pick_t;

  typedef struct {
    in_item_t  item;
    seq_pick_t pick;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_LOCAL_ADDR;
  logic [47:0] cfg_wdata = '0;

  // Model copy of the configuration
  logic [47:0] own_addr = RST_LOCAL_ADDR;
  logic [47:0] peer_addr = RST_PEER_ADDR;
  logic [15:0] ack_wait_cfg = RST_ACK_TIMEOUT;
  logic [7:0]  retry_cfg = RST_MAX_RETRIES;

  // Model copy of the engine state
  logic [31:0] tx_seq_m = SEQ_FIRST;
  logic [31:0] rx_last_m = '0;
  phase_t      phase_m = PH_IDLE;
  logic [16:0] wait_m = '0;
  logic [8:0]  sends_m = '0;
  logic [7:0]  queued_m = '0;
  logic [15:0] lfsr_m = LFSR_SEED;

  stim_t       pending_items[$];
  out_item_t   expected_actions[$];

  int          calm_left = 0;
  int          stall_cycles = 0;
  int          mismatches = 0;
  int          settings_used = 1;
  int          cmd_seen[4] = '{default: 0};
  int          act_seen[8] = '{default: 0};

  always #4 clk = ~clk;

  aloha_stop_and_wait_arq_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Engine model
  // ---------------------------------------------------------------------

  function automatic void post(input logic [2:0] act, input logic [47:0] src,
                               input logic [47:0] dst, input logic [31:0] seq,
                               input logic [1:0] err);
    out_item_t r;
    r.action = act;
    r.out_src = src;
    r.out_dst = dst;
    r.out_seqno = seq;
    r.error_code = err;
    r.last = 1'b0;
    expected_actions = {expected_actions, r};
  endfunction

  // A programmed timeout of zero behaves as one tick
  function automatic int ack_wait_ticks();
    return (ack_wait_cfg == 16'd0) ? 1 : int'(ack_wait_cfg);
  endfunction

  function automatic void send_frame();
    sends_m = sends_m + 9'd1;
    phase_m = PH_WAIT;
    wait_m = 17'(ack_wait_ticks());
    post(ACT_SEND_DATA, own_addr, peer_addr, tx_seq_m, ERR_NONE);
  endfunction

  function automatic void start_queued();
    if (phase_m == PH_IDLE && queued_m != 8'd0) begin
      queued_m = queued_m - 8'd1;
      sends_m = '0;
      send_frame();
    end
  endfunction

  // Close the frame in flight, advance the sequence number, start the next one
  function automatic void close_frame(input logic [2:0] act);
    post(act, '0, '0, tx_seq_m, ERR_NONE);
    tx_seq_m = tx_seq_m + 32'd1;
    if (tx_seq_m == 32'hFFFF_FFFF) tx_seq_m = SEQ_FIRST;
    phase_m = PH_IDLE;
    wait_m = '0;
    sends_m = '0;
    start_queued();
  endfunction

  function automatic void on_tick();
    int t;
    logic lsb;
    if (phase_m == PH_IDLE) return;
    if (wait_m != 17'd0) wait_m = wait_m - 17'd1;
    if (wait_m != 17'd0) return;
    if (phase_m == PH_WAIT) begin
      // Step the Galois LFSR and size the backoff from it
      t = ack_wait_ticks();
      lsb = lfsr_m[0];
      lfsr_m = lfsr_m >> 1;
      if (lsb) lfsr_m = lfsr_m ^ LFSR_TAPS;
      phase_m = PH_BACKOFF;
      wait_m = 17'(t + int'(lfsr_m) % t);
    end else if (int'(sends_m) >= int'(retry_cfg) + 1) begin
      close_frame(ACT_GAVE_UP);
    end else begin
      send_frame();
    end
  endfunction

  function automatic void on_frame(input in_item_t it);
    if (it.frame_dst != own_addr) return;
    case (it.frame_kind)
      KIND_DATA: begin
        post(ACT_SEND_ACK, own_addr, it.frame_src, it.frame_seqno, ERR_NONE);
        if (it.frame_seqno > rx_last_m || it.frame_seqno == SEQ_FIRST) begin
          post(ACT_DELIVER, it.frame_src, it.frame_dst, it.frame_seqno, ERR_NONE);
          rx_last_m = it.frame_seqno;
        end
      end
      KIND_ACK: begin
        if (it.frame_seqno == tx_seq_m) begin
          if (phase_m != PH_IDLE) close_frame(ACT_ACKED);
        end else if (it.frame_seqno > tx_seq_m) begin
          post(ACT_ERROR, '0, '0, it.frame_seqno, ERR_FUTURE_ACK);
        end else begin
          post(ACT_ERROR, '0, '0, it.frame_seqno, ERR_OLD_ACK);
        end
      end
      default: begin
        post(ACT_ERROR, '0, '0, it.frame_seqno, ERR_UNDEFINED);
      end
    endcase
  endfunction

  // Apply one accepted input transaction and queue the results it causes
  function automatic void engine_react(input in_item_t it);
    int before_cnt;
    out_item_t tail;
    before_cnt = expected_actions.size();
    case (it.command)
      CMD_REQUEST: begin
        if (int'(queued_m) >= QUEUE_DEPTH) post(ACT_ERROR, '0, '0, '0, ERR_UNDEFINED);
        else queued_m = queued_m + 8'd1;
        start_queued();
      end
      CMD_FRAME: on_frame(it);
      CMD_TICK:  on_tick();
      default: ;
    endcase
    // Mark the final result of this transaction
    if (expected_actions.size() > before_cnt) begin
      tail = expected_actions.pop_back();
      tail.last = 1'b1;
      expected_actions = {expected_actions, tail};
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 65535)), 32'($urandom())};
  endfunction

  // Item with every field random; callers override what matters
  function automatic stim_t noise_item();
    stim_t s;
    s.item.command = 2'($urandom_range(0, 3));
    s.item.frame_dst = rand48();
    s.item.frame_src = rand48();
    s.item.frame_kind = 2'($urandom_range(0, 3));
    s.item.frame_seqno = $urandom();
    s.pick = SEQ_AS_GIVEN;
    return s;
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic [1:0] kind,
                          input logic [31:0] seq, input seq_pick_t pick);
    stim_t s;
    s = noise_item();
    s.item.command = cmd;
    s.item.frame_dst = own_addr;
    s.item.frame_kind = kind;
    s.item.frame_seqno = seq;
    s.pick = pick;
    pending_items = {pending_items, s};
  endtask

  // Mostly well-formed traffic (requests, tick runs, matching ACKs, local DATA)
  // with some stale/future ACKs, bad kinds, foreign frames and unused commands
  task automatic add_traffic(input int want);
    int got;
    int roll;
    int n;
    stim_t s;
    got = 0;
    while (got < want) begin
      s = noise_item();
      s.item.frame_dst = own_addr;
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        s.item.command = CMD_REQUEST;
      end else if (roll < 55) begin
        n = $urandom_range(1, 3);
        s.item.command = CMD_TICK;
        repeat (n) pending_items = {pending_items, s};
        got += n;
        continue;
      end else if (roll < 72) begin
        s.item.command = CMD_FRAME;
        s.item.frame_kind = KIND_ACK;
        s.pick = SEQ_OWN_CUR;
      end else if (roll < 84) begin
        s.item.command = CMD_FRAME;
        s.item.frame_kind = KIND_DATA;
        roll = $urandom_range(0, 3);
        if (roll < 2) s.pick = SEQ_PEER_NEXT;
        else if (roll == 2) s.item.frame_seqno = $urandom_range(0, 3);
      end else if (roll < 90) begin
        s.item.command = CMD_FRAME;
        s.item.frame_kind = KIND_ACK;
        roll = $urandom_range(0, 2);
        s.pick = (roll == 0) ? SEQ_OWN_AHEAD : (roll == 1) ? SEQ_OWN_BEHIND : SEQ_AS_GIVEN;
      end else if (roll < 94) begin
        s.item.command = CMD_FRAME;
        s.item.frame_kind = $urandom_range(0, 1) ? KIND_UNDEF_LO : KIND_UNDEF_HI;
      end else if (roll < 97) begin
        // Foreign frame: ignored, so not counted
        s.item.command = CMD_FRAME;
        s.item.frame_dst = own_addr ^ (rand48() | 48'd1);
        pending_items = {pending_items, s};
        continue;
      end else begin
        s.item.command = CMD_UNUSED;
        pending_items = {pending_items, s};
        continue;
      end
      pending_items = {pending_items, s};
      got++;
    end
  endtask

  // Wait until every item is accepted and every result has arrived
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_actions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic apply_settings(input logic [47:0] own, input logic [47:0] peer,
                                input logic [15:0] tmo, input logic [7:0] rtr);
    logic [47:0] vals[4];
    vals[CFG_LOCAL_ADDR] = own;
    vals[CFG_PEER_ADDR] = peer;
    vals[CFG_ACK_TIMEOUT] = 48'(tmo);
    vals[CFG_MAX_RETRIES] = 48'(rtr);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    own_addr = own;
    peer_addr = peer;
    ack_wait_cfg = tmo;
    retry_cfg = rtr;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Idle pattern: hold both sides busy-free during occasional calm stretches
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (calm_left > 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 399) == 0) calm_left <= $urandom_range(200, 500);
  end

  // ---------------------------------------------------------------------
  // Driver: predict on acceptance, then present the next pending item
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive
    stim_t s;
    in_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        engine_react(in_data);
        cmd_seen[in_data.command]++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (calm_left != 0 || $urandom_range(0, 99) >= 25)) begin
          s = pending_items.pop_front();
          it = s.item;
          case (s.pick)
            SEQ_OWN_CUR:    it.frame_seqno = tx_seq_m;
            SEQ_OWN_AHEAD:  it.frame_seqno = tx_seq_m + 32'd1;
            SEQ_OWN_BEHIND: it.frame_seqno = tx_seq_m - 32'd1;
            SEQ_PEER_NEXT:  it.frame_seqno = rx_last_m + 32'd1;
            default: ;
          endcase
          in_data <= it;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each result transaction against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        act_seen[got.action]++;
        if (expected_actions.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%t: unexpected result act=%0d src=%h dst=%h seq=%h err=%0d last=%0b",
                     $time, got.action, got.out_src, got.out_dst, got.out_seqno,
                     got.error_code, got.last);
        end else begin
          want = expected_actions.pop_front();
          if (got.action !== want.action || got.out_src !== want.out_src ||
              got.out_dst !== want.out_dst || got.out_seqno !== want.out_seqno ||
              got.error_code !== want.error_code || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%t: result mismatch", $time);
              $display("  expected act=%0d src=%h dst=%h seq=%h err=%0d last=%0b",
                       want.action, want.out_src, want.out_dst, want.out_seqno,
                       want.error_code, want.last);
              $display("  actual   act=%0d src=%h dst=%h seq=%h err=%0d last=%0b",
                       got.action, got.out_src, got.out_dst, got.out_seqno,
                       got.error_code, got.last);
            end
          end
        end
      end
      out_ready <= (calm_left != 0) || ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%t: no transaction for %0d cycles", $time, stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle behavior, receive path, ACK checks, two requests, the second queued
    add_item(CMD_TICK, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_item(CMD_UNUSED, KIND_DATA, '0, SEQ_AS_GIVEN);
    pending_items = {pending_items, noise_item()};
    pending_items[$].item.command = CMD_FRAME;
    pending_items[$].item.frame_dst = ~own_addr;
    add_item(CMD_FRAME, KIND_DATA, 32'd5, SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_DATA, 32'd3, SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_DATA, SEQ_FIRST, SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_DATA, 32'hFFFF_FFFF, SEQ_AS_GIVEN);
    pending_items[$].item.frame_src = '1;
    add_item(CMD_FRAME, KIND_DATA, '0, SEQ_AS_GIVEN);
    pending_items[$].item.frame_src = '0;
    add_item(CMD_FRAME, KIND_ACK, SEQ_FIRST, SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_ACK, '0, SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_ACK, 32'hFFFF_FFFF, SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_UNDEF_LO, $urandom(), SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_UNDEF_HI, $urandom(), SEQ_AS_GIVEN);
    add_item(CMD_REQUEST, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_item(CMD_REQUEST, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_ACK, '0, SEQ_OWN_CUR);
    add_item(CMD_FRAME, KIND_ACK, '0, SEQ_OWN_CUR);
    drain();

    // Zero timeout, no retries: give up after one send, then an ACK in backoff
    apply_settings('0, '1, 16'd0, 8'd0);
    add_item(CMD_REQUEST, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_item(CMD_TICK, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_item(CMD_TICK, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_item(CMD_REQUEST, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_item(CMD_TICK, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_item(CMD_FRAME, KIND_ACK, '0, SEQ_OWN_CUR);
    add_traffic(60);
    drain();

    // Largest timeout and retry count
    apply_settings('1, '0, 16'hFFFF, 8'hFF);
    add_traffic(40);
    drain();

    // Short random timeouts so that backoff, retransmission and give-up recur
    repeat (3) begin
      apply_settings(rand48(), rand48(), 16'($urandom_range(1, 4)), 8'($urandom_range(0, 3)));
      add_traffic(60);
      drain();
    end

    // Flood the request queue past its depth, then some normal traffic
    apply_settings(rand48(), rand48(), 16'd1, 8'd1);
    repeat (QUEUE_DEPTH + 4) add_item(CMD_REQUEST, KIND_DATA, '0, SEQ_AS_GIVEN);
    add_traffic(20);
    drain();

    $display("Covered %0d requests, %0d frames, %0d ticks, %0d unused commands under %0d settings",
             cmd_seen[CMD_REQUEST], cmd_seen[CMD_FRAME], cmd_seen[CMD_TICK],
             cmd_seen[CMD_UNUSED], settings_used);
    $display("Results: %0d sends, %0d acks, %0d deliveries, %0d acked, %0d gave up, %0d errors",
             act_seen[ACT_SEND_DATA], act_seen[ACT_SEND_ACK], act_seen[ACT_DELIVER],
             act_seen[ACT_ACKED], act_seen[ACT_GAVE_UP], act_seen[ACT_ERROR]);
    if (expected_actions.size() != 0) begin
      $display("%0d expected results never arrived", expected_actions.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
